// File: design/atsd_pkg.sv
package atsd_pkg;

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 11;
    localparam int COUNT_W      = 16;
    localparam int BANK_W       = 4;
    localparam int ATTRIB_W     = 5;
    localparam int STYLE_W      = 4;
    localparam int CHAR_W       = 7;
    localparam int ACCUM_W      = 17;
    localparam int DIGIT_W      = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 7;

    // Repeat run limits
    localparam int MAX_RUN_DIGITS = 4;
    localparam logic [ACCUM_W-1:0] ACC_MAX   = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Special bytes
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [3:0]        RUN_PREFIX   = 4'h8;

    // Escape groups, taken from bits 6..4 of an escape byte
    typedef enum logic [2:0] {
        ESC_RUN     = 3'h0,
        ESC_BANK    = 3'h1,
        ESC_ATTR_LO = 3'h2,
        ESC_ATTR_HI = 3'h3,
        ESC_COLOR_A = 3'h4,
        ESC_SIZE    = 3'h5,
        ESC_STYLE   = 3'h6,
        ESC_COLOR_B = 3'h7
    } esc_grp_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PHI_ENABLED       = 3'd0,
        REG_HIDDEN_MASK       = 3'd1,
        REG_DEFAULT_BANK      = 3'd2,
        REG_DEFAULT_ATTRIB    = 3'd3,
        REG_DEFAULT_STYLE     = 3'd4,
        REG_DEFAULT_LAST_CHAR = 3'd5
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [ATTRIB_W-1:0] RST_HIDDEN_MASK = 5'd1;
    localparam logic [CHAR_W-1:0]   RST_LAST_CHAR   = 7'h7F;

    typedef struct packed {
        logic                phi_enabled;
        logic [ATTRIB_W-1:0] hidden_mask;
        logic [BANK_W-1:0]   default_bank;
        logic [ATTRIB_W-1:0] default_attrib;
        logic [STYLE_W-1:0]  default_style;
        logic [CHAR_W-1:0]   default_last_char;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] run_count;
        logic               last;
    } res_t;

    // Results of one byte, packed from slot 0
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

// File: design/atsd_ifs.sv
interface atsd_byte_if;
    import atsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface atsd_res_if;
    import atsd_pkg::*;
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] run_count;
    logic               last;
    modport source (output valid, output code, output run_count, output last, input ready);
    modport sink   (input valid, input code, input run_count, input last, output ready);
endinterface

interface atsd_cfg_if;
    import atsd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// File: design/atsd_cfg.sv
module atsd_cfg (
    input  logic           clk,
    input  logic           rst_n,
    atsd_cfg_if.sink       cfg_ch,
    output atsd_pkg::cfg_t cfg
);
    import atsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    // Register write decode; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.addr)
                REG_PHI_ENABLED:       cfg_next.phi_enabled       = cfg_ch.wdata[0];
                REG_HIDDEN_MASK:       cfg_next.hidden_mask       = cfg_ch.wdata[ATTRIB_W-1:0];
                REG_DEFAULT_BANK:      cfg_next.default_bank      = cfg_ch.wdata[BANK_W-1:0];
                REG_DEFAULT_ATTRIB:    cfg_next.default_attrib    = cfg_ch.wdata[ATTRIB_W-1:0];
                REG_DEFAULT_STYLE:     cfg_next.default_style     = cfg_ch.wdata[STYLE_W-1:0];
                REG_DEFAULT_LAST_CHAR: cfg_next.default_last_char = cfg_ch.wdata[CHAR_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phi_enabled       <= 1'b0;
            cfg_reg.hidden_mask       <= RST_HIDDEN_MASK;
            cfg_reg.default_bank      <= '0;
            cfg_reg.default_attrib    <= '0;
            cfg_reg.default_style     <= '0;
            cfg_reg.default_last_char <= RST_LAST_CHAR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/atsd_core.sv
module atsd_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atsd_pkg::cfg_t              cfg,
    input  logic                        fire,
    input  logic [atsd_pkg::BYTE_W-1:0] byte_in,
    output atsd_pkg::push_t             push
);
    import atsd_pkg::*;

    logic [BANK_W-1:0]   bank_reg,   bank_next;
    logic [ATTRIB_W-1:0] attrib_reg, attrib_next;
    logic [STYLE_W-1:0]  style_reg,  style_next;
    logic [CHAR_W-1:0]   char_reg,   char_next;
    logic [ACCUM_W-1:0]  accum_reg,  accum_next;
    logic [DIGIT_W-1:0]  digit_reg,  digit_next;
    logic                in_run_reg, in_run_next;

    logic               is_run_byte;
    logic               hidden;
    logic [ACCUM_W-1:0] digit_add;
    logic [ACCUM_W:0]   accum_sum;
    logic [ACCUM_W:0]   count_sum;
    logic [COUNT_W-1:0] run_count;
    res_t               run_res;
    res_t               byte_res;
    logic               byte_emit;
    esc_grp_t           grp;

    assign is_run_byte = (byte_in[BYTE_W-1:4] == RUN_PREFIX);
    assign hidden      = (|(attrib_reg & cfg.hidden_mask)) || (style_reg != '0);
    assign grp         = esc_grp_t'(byte_in[6:4]);

    // Next digit weight: nibble shifted up by four bits per digit, plus one.
    assign digit_add = (ACCUM_W'(byte_in[3:0]) << {digit_reg[1:0], 2'b00}) + ACCUM_W'(1);
    assign accum_sum = {1'b0, accum_reg} + {1'b0, digit_add};

    // Count of a finished run, saturated to the output width.
    assign count_sum = {1'b0, accum_reg} + (ACCUM_W+1)'(1);
    assign run_count = (count_sum > (ACCUM_W+1)'(COUNT_MAX)) ? COUNT_MAX
                                                             : count_sum[COUNT_W-1:0];

    assign run_res.code      = {bank_reg, char_reg};
    assign run_res.run_count = run_count;
    assign run_res.last      = 1'b0;

    // Decode of one byte: state update and up to two results.
    always_comb
    begin
        bank_next   = bank_reg;
        attrib_next = attrib_reg;
        style_next  = style_reg;
        char_next   = char_reg;
        accum_next  = accum_reg;
        digit_next  = digit_reg;
        in_run_next = in_run_reg;

        byte_res.code      = CODE_W'(byte_in);
        byte_res.run_count = COUNT_W'(1);
        byte_res.last      = 1'b1;
        byte_emit          = 1'b0;

        push.num = 2'd0;
        push.r0  = byte_res;
        push.r1  = byte_res;

        if (!cfg.phi_enabled)
        begin
            // Pass-through mode: the raw byte, state untouched.
            push.num = 2'd1;
        end
        else if (is_run_byte)
        begin
            // Repeat count digit.
            if (!in_run_reg)
            begin
                in_run_next = 1'b1;
                accum_next  = ACCUM_W'(byte_in[3:0]) + ACCUM_W'(1);
                digit_next  = DIGIT_W'(1);
            end
            else if (digit_reg < DIGIT_W'(MAX_RUN_DIGITS))
            begin
                accum_next = (accum_sum > (ACCUM_W+1)'(ACC_MAX)) ? ACC_MAX
                                                                 : accum_sum[ACCUM_W-1:0];
                digit_next = digit_reg + DIGIT_W'(1);
            end
            else
            begin
                accum_next = ACC_MAX;
            end
        end
        else
        begin
            if (in_run_reg)
            begin
                in_run_next = 1'b0;
                accum_next  = '0;
                digit_next  = '0;
            end

            if (byte_in[BYTE_W-1])
            begin
                // Escape byte: bank, attribute or style change; other groups change nothing.
                unique case (grp) inside
                    ESC_BANK:                 bank_next   = byte_in[BANK_W-1:0];
                    ESC_ATTR_LO, ESC_ATTR_HI: attrib_next = byte_in[ATTRIB_W-1:0];
                    ESC_STYLE:                style_next  = byte_in[STYLE_W-1:0];
                    default:                  bank_next   = bank_reg;
                endcase
            end
            else
            begin
                if (byte_in != CHAR_NUL)
                begin
                    char_next = byte_in[CHAR_W-1:0];
                end
                if (|byte_in[6:5])
                begin
                    // Printable: banked, unless hidden or styled.
                    byte_res.code = {bank_reg, byte_in[CHAR_W-1:0]};
                    byte_emit     = !hidden;
                end
                else
                begin
                    // Control byte: unbanked; newline restores the defaults.
                    byte_emit = 1'b1;
                    if (byte_in == CHAR_NEWLINE)
                    begin
                        bank_next   = cfg.default_bank;
                        attrib_next = cfg.default_attrib;
                        style_next  = cfg.default_style;
                        char_next   = cfg.default_last_char;
                    end
                end
            end

            // Pack the results from slot zero; the last one carries the flag.
            if (in_run_reg)
            begin
                push.r0      = run_res;
                push.r0.last = !byte_emit;
                push.r1      = byte_res;
                push.num     = byte_emit ? 2'd2 : 2'd1;
            end
            else
            begin
                push.r0  = byte_res;
                push.num = byte_emit ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= '0;
            attrib_reg <= '0;
            style_reg  <= '0;
            char_reg   <= RST_LAST_CHAR;
            accum_reg  <= '0;
            digit_reg  <= '0;
            in_run_reg <= 1'b0;
        end
        else if (fire)
        begin
            bank_reg   <= bank_next;
            attrib_reg <= attrib_next;
            style_reg  <= style_next;
            char_reg   <= char_next;
            accum_reg  <= accum_next;
            digit_reg  <= digit_next;
            in_run_reg <= in_run_next;
        end
    end

endmodule

// File: design/atsd_outq.sv
module atsd_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_en,
    input  atsd_pkg::push_t push,
    output logic            space,
    atsd_res_if.source      res_ch
);
    import atsd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    res_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic             pop;
    logic [PTR_W:0]   count_after_pop;
    logic [1:0]       num_in;

    assign res_ch.valid     = (count_reg != '0);
    assign res_ch.code      = entry_reg[rd_ptr_reg].code;
    assign res_ch.run_count = entry_reg[rd_ptr_reg].run_count;
    assign res_ch.last      = entry_reg[rd_ptr_reg].last;

    assign pop             = res_ch.valid && res_ch.ready;
    assign count_after_pop = count_reg - (PTR_W+1)'(pop);

    // Room for the two results one byte can cause.
    assign space  = (count_after_pop <= (PTR_W+1)'(DEPTH - 2));
    assign num_in = push_en ? push.num : 2'd0;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(num_in);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_after_pop + (PTR_W+1)'(num_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; results of one byte go to consecutive entries.
    always_ff @(posedge clk)
    begin
        if (num_in != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (num_in == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push.r1;
        end
    end

endmodule

// File: design/attributed_text_stream_decoder.sv
// Channel   Direction  Payload                     Accepted when
// byte_ch   in         byte_in[7:0]                valid && ready
// res_ch    out        code[10:0], run_count[15:0], last   valid && ready
// cfg_ch    in         addr[2:0], wdata[6:0]       valid && ready (ready is always high)
//
// One byte per cycle while the output queue has room: a byte is held in the
// input register, is decoded there, and its results enter a four-entry output
// queue in the same cycle. A byte that ends a repeat run can give two results,
// so the output side, at one result per cycle, sets the rate. Reset clears the
// queue and input register and loads the register reset values. A stalled output
// fills the queue; the input register then holds its byte and drops ready.
module attributed_text_stream_decoder (
    input  logic       clk,
    input  logic       rst_n,
    atsd_byte_if.sink  byte_ch,
    atsd_res_if.source res_ch,
    atsd_cfg_if.sink   cfg_ch
);
    import atsd_pkg::*;

    cfg_t              cfg;
    push_t             push;
    logic              space;
    logic              advance;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign advance       = in_valid_reg && space;
    assign byte_ch.ready = !in_valid_reg || advance;

    // Input register.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (byte_ch.ready)
        begin
            in_valid_next = byte_ch.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            byte_reg <= byte_ch.byte_in;
        end
    end

    atsd_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    atsd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fire    (advance),
        .byte_in (byte_reg),
        .push    (push)
    );

    atsd_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (advance),
        .push    (push),
        .space   (space),
        .res_ch  (res_ch)
    );

endmodule
